FILE: rtl/bphe_pkg.sv
// ----------------------------------------------------------------------------
// bphe_pkg
// Shared widths, codes and configuration type of the box placement hole engine.
// ----------------------------------------------------------------------------
package bphe_pkg;

    localparam int DIM_W      = 12;
    localparam int WT_W       = 16;
    localparam int VOL_W      = 3 * DIM_W;
    localparam int HOLE_DEPTH = 32;
    localparam int NLIST      = 3;
    localparam int CNT_W      = $clog2(HOLE_DEPTH + 1);
    localparam int IDX_W      = $clog2(HOLE_DEPTH);
    localparam int LIST_W     = 2;
    localparam int MEM_DEPTH  = NLIST * HOLE_DEPTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int KIND_W     = 3;
    localparam int ROT_W      = 3;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // hole lists, searched in this order
    localparam logic [LIST_W-1:0] LIST_FRONT  = 2'd0;
    localparam logic [LIST_W-1:0] LIST_ABOVE  = 2'd1;
    localparam logic [LIST_W-1:0] LIST_BESIDE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FRONT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ABOVE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BESIDE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LEVEL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd4;

    localparam logic [ROT_W-1:0] ROT_LWH = 3'd1;
    localparam logic [ROT_W-1:0] ROT_HLW = 3'd2;
    localparam logic [ROT_W-1:0] ROT_LHW = 3'd3;
    localparam logic [ROT_W-1:0] ROT_WHL = 3'd4;
    localparam logic [ROT_W-1:0] ROT_HWL = 3'd5;

    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_WLIMIT = 2'd3;

    localparam logic [DIM_W-1:0] RST_LENGTH = 12'd1200;
    localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd235;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd239;
    localparam logic [WT_W-1:0]  RST_WLIMIT = 16'hFFFF;

    typedef struct packed {
        logic [DIM_W-1:0] length;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [WT_W-1:0]  weight_limit;
    } cfg_t;

endpackage

FILE: rtl/bphe_core.sv
// ----------------------------------------------------------------------------
// bphe_core
// Placement sequencer: hole lists in one synchronous memory, volume products
// on a shared multiplier, sorted insertion by shifting entries from the top.
// ----------------------------------------------------------------------------
module bphe_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bphe_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_start_new,
    input  logic [bphe_pkg::DIM_W-1:0]    s_box_length,
    input  logic [bphe_pkg::DIM_W-1:0]    s_box_width,
    input  logic [bphe_pkg::DIM_W-1:0]    s_box_height,
    input  logic [bphe_pkg::WT_W-1:0]     s_box_weight,
    input  logic [bphe_pkg::ROT_W-1:0]    s_rotation,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_placed,
    output logic [bphe_pkg::KIND_W-1:0]   m_place_kind,
    output logic                          m_stopped,
    output logic                          m_hole_overflow,
    output logic [bphe_pkg::VOL_W-1:0]    m_packed_volume,
    output logic [bphe_pkg::WT_W-1:0]     m_packed_weight
);

    localparam int DW = bphe_pkg::DIM_W;
    localparam int VW = bphe_pkg::VOL_W;
    localparam int CW = bphe_pkg::CNT_W;
    localparam int AW = bphe_pkg::ADDR_W;
    localparam int IW = bphe_pkg::IDX_W;
    localparam int LW = bphe_pkg::LIST_W;

    typedef struct packed {
        logic [VW-1:0] vol;
        logic [DW-1:0] h;
        logic [DW-1:0] l;
        logic [DW-1:0] w;
    } hole_t;

    typedef enum logic [4:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_CHK, S_SRD, S_SCMP, S_RMR, S_RMW,
        S_NEWL, S_IN0, S_IM0, S_IM1, S_IPOS, S_IR, S_IW, S_FIN, S_OUT
    } state_t;

    function automatic logic [AW-1:0] hole_addr(input logic [LW-1:0] lst,
                                                input logic [IW-1:0] idx);
        return AW'(lst) * AW'(bphe_pkg::HOLE_DEPTH) + AW'(idx);
    endfunction

    state_t            state_reg;
    hole_t             mem [bphe_pkg::MEM_DEPTH];
    hole_t             rd_reg;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    hole_t             wr_data;

    logic [CW-1:0]     cnt_reg [bphe_pkg::NLIST];
    logic [DW-1:0]     pend_w_reg [bphe_pkg::NLIST];
    logic [DW-1:0]     pend_l_reg [bphe_pkg::NLIST];
    logic [DW-1:0]     pend_h_reg [bphe_pkg::NLIST];
    logic [bphe_pkg::NLIST-1:0] pend_v_reg;

    logic [LW-1:0]     lst_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     j_reg;
    logic [DW-1:0]     bw_reg, bl_reg, bh_reg;
    logic [bphe_pkg::WT_W-1:0] wt_reg;
    logic [VW-1:0]     bv_reg, prod_reg;
    logic [2*DW-1:0]   mul_a;
    logic [DW-1:0]     mul_b;
    logic [VW-1:0]     mul_p;
    logic [DW-1:0]     fw_reg;
    logic [VW-1:0]     vt_reg;
    logic [bphe_pkg::WT_W-1:0] wtt_reg;
    logic              stop_reg;
    logic              ovf_reg;
    logic [bphe_pkg::KIND_W-1:0] kind_reg;
    logic              acc;
    logic              over_lim;
    logic              fits;
    hole_t             new_hole;
    logic [DW-1:0]     rw, rl, rh;

    assign s_ready = (state_reg == S_IDLE);
    assign acc     = s_valid && s_ready;

    // rotation decode; unused codes fall back to the plain orientation
    always_comb begin
        case (s_rotation)
            bphe_pkg::ROT_LWH: begin rw = s_box_length; rl = s_box_width;  rh = s_box_height; end
            bphe_pkg::ROT_HLW: begin rw = s_box_height; rl = s_box_length; rh = s_box_width;  end
            bphe_pkg::ROT_LHW: begin rw = s_box_length; rl = s_box_height; rh = s_box_width;  end
            bphe_pkg::ROT_WHL: begin rw = s_box_width;  rl = s_box_height; rh = s_box_length; end
            bphe_pkg::ROT_HWL: begin rw = s_box_height; rl = s_box_width;  rh = s_box_length; end
            default:           begin rw = s_box_width;  rl = s_box_length; rh = s_box_height; end
        endcase
    end

    // shared multiplier, result always registered in prod_reg
    always_comb begin
        case (state_reg)
            S_M0:    begin mul_a = (2*DW)'(bw_reg);          mul_b = bl_reg; end
            S_M1:    begin mul_a = prod_reg[2*DW-1:0];       mul_b = bh_reg; end
            S_M2:    begin mul_a = (2*DW)'(cfg.length);      mul_b = cfg.width; end
            S_M3:    begin mul_a = prod_reg[2*DW-1:0];       mul_b = cfg.height; end
            S_IM0:   begin mul_a = (2*DW)'(pend_w_reg[lst_reg]); mul_b = pend_l_reg[lst_reg]; end
            S_IM1:   begin mul_a = prod_reg[2*DW-1:0];       mul_b = pend_h_reg[lst_reg]; end
            default: begin mul_a = '0;                       mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // container volume sits in prod_reg during S_CHK
    assign over_lim = (({1'b0, wtt_reg} + {1'b0, wt_reg}) > {1'b0, cfg.weight_limit}) ||
                      (({1'b0, vt_reg} + {1'b0, bv_reg}) > {1'b0, prod_reg});
    assign fits     = (rd_reg.w >= bw_reg) && (rd_reg.l >= bl_reg) && (rd_reg.h >= bh_reg);

    assign new_hole = '{vol: prod_reg, h: pend_h_reg[lst_reg], l: pend_l_reg[lst_reg],
                        w: pend_w_reg[lst_reg]};

    // memory port control
    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_reg;
        case (state_reg)
            S_SRD: rd_addr = hole_addr(lst_reg, idx_reg[IW-1:0]);
            S_RMR: rd_addr = hole_addr(lst_reg, IW'(j_reg + CW'(1)));
            S_RMW: begin
                wr_en   = 1'b1;
                wr_addr = hole_addr(lst_reg, j_reg[IW-1:0]);
            end
            S_IR: begin
                rd_addr = hole_addr(lst_reg, IW'(j_reg - CW'(1)));
                if (j_reg == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = hole_addr(lst_reg, '0);
                    wr_data = new_hole;
                end
            end
            S_IW: begin
                wr_en   = 1'b1;
                wr_addr = hole_addr(lst_reg, j_reg[IW-1:0]);
                if (rd_reg.vol <= prod_reg) begin
                    wr_data = new_hole;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '{default: '0};
            pend_v_reg <= '0;
            fw_reg     <= bphe_pkg::RST_WIDTH;
            vt_reg     <= '0;
            wtt_reg    <= '0;
            stop_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            if (m_valid && m_ready && (state_reg != S_OUT)) begin
                m_valid <= 1'b0;
            end
            if (state_t'(state_reg) inside {S_M0, S_M1, S_M2, S_M3, S_IM0, S_IM1}) begin
                prod_reg <= mul_p;
            end
            case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        bw_reg   <= rw;
                        bl_reg   <= rl;
                        bh_reg   <= rh;
                        wt_reg   <= s_box_weight;
                        ovf_reg  <= 1'b0;
                        kind_reg <= bphe_pkg::KIND_NONE;
                        if (s_start_new) begin
                            cnt_reg  <= '{default: '0};
                            fw_reg   <= cfg.width;
                            vt_reg   <= '0;
                            wtt_reg  <= '0;
                            stop_reg <= 1'b0;
                        end
                        state_reg <= S_M0;
                    end
                end
                S_M0: state_reg <= S_M1;
                S_M1: state_reg <= S_M2;
                S_M2: begin
                    bv_reg    <= prod_reg;
                    state_reg <= S_M3;
                end
                S_M3: state_reg <= S_CHK;
                S_CHK: begin
                    if (stop_reg || over_lim) begin
                        stop_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end else begin
                        lst_reg   <= bphe_pkg::LIST_FRONT;
                        idx_reg   <= '0;
                        state_reg <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (idx_reg == cnt_reg[lst_reg]) begin
                        idx_reg <= '0;
                        if (lst_reg == bphe_pkg::LIST_BESIDE) begin
                            state_reg <= S_NEWL;
                        end else begin
                            lst_reg <= lst_reg + LW'(1);
                        end
                    end else begin
                        state_reg <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (fits) begin
                        kind_reg <= {1'b0, lst_reg};
                        pend_w_reg[bphe_pkg::LIST_BESIDE] <= rd_reg.w - bw_reg;
                        pend_l_reg[bphe_pkg::LIST_BESIDE] <= bl_reg;
                        pend_h_reg[bphe_pkg::LIST_BESIDE] <= bh_reg;
                        pend_w_reg[bphe_pkg::LIST_ABOVE]  <= rd_reg.w;
                        pend_l_reg[bphe_pkg::LIST_ABOVE]  <= rd_reg.l;
                        pend_h_reg[bphe_pkg::LIST_ABOVE]  <= rd_reg.h - bh_reg;
                        pend_w_reg[bphe_pkg::LIST_FRONT]  <= rd_reg.w;
                        pend_l_reg[bphe_pkg::LIST_FRONT]  <= rd_reg.l - bl_reg;
                        pend_h_reg[bphe_pkg::LIST_FRONT]  <= bh_reg;
                        pend_v_reg[bphe_pkg::LIST_BESIDE] <= rd_reg.w > bw_reg;
                        pend_v_reg[bphe_pkg::LIST_ABOVE]  <= rd_reg.h > bh_reg;
                        pend_v_reg[bphe_pkg::LIST_FRONT]  <= rd_reg.l > bl_reg;
                        j_reg     <= idx_reg;
                        state_reg <= S_RMR;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SRD;
                    end
                end
                S_RMR: begin
                    if ((j_reg + CW'(1)) >= cnt_reg[lst_reg]) begin
                        cnt_reg[lst_reg] <= cnt_reg[lst_reg] - CW'(1);
                        lst_reg          <= bphe_pkg::LIST_FRONT;
                        state_reg        <= S_IN0;
                    end else begin
                        state_reg <= S_RMW;
                    end
                end
                S_RMW: begin
                    // close the gap: entry j+1 moves down to j
                    j_reg     <= j_reg + CW'(1);
                    state_reg <= S_RMR;
                end
                S_NEWL: begin
                    if (bw_reg <= fw_reg) begin
                        fw_reg   <= fw_reg - bw_reg;
                        kind_reg <= bphe_pkg::KIND_LEVEL;
                        pend_w_reg[bphe_pkg::LIST_FRONT] <= bw_reg;
                        pend_l_reg[bphe_pkg::LIST_FRONT] <= cfg.length - bl_reg;
                        pend_h_reg[bphe_pkg::LIST_FRONT] <= bh_reg;
                        pend_w_reg[bphe_pkg::LIST_ABOVE] <= bw_reg;
                        pend_l_reg[bphe_pkg::LIST_ABOVE] <= cfg.length;
                        pend_h_reg[bphe_pkg::LIST_ABOVE] <= cfg.height - bh_reg;
                        pend_v_reg[bphe_pkg::LIST_FRONT]  <= cfg.length > bl_reg;
                        pend_v_reg[bphe_pkg::LIST_ABOVE]  <= cfg.height > bh_reg;
                        pend_v_reg[bphe_pkg::LIST_BESIDE] <= 1'b0;
                        lst_reg   <= bphe_pkg::LIST_FRONT;
                        state_reg <= S_IN0;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_IN0: begin
                    if (pend_v_reg[lst_reg]) begin
                        state_reg <= S_IM0;
                    end else if (lst_reg == bphe_pkg::LIST_BESIDE) begin
                        state_reg <= S_FIN;
                    end else begin
                        lst_reg <= lst_reg + LW'(1);
                    end
                end
                S_IM0: state_reg <= S_IM1;
                S_IM1: state_reg <= S_IPOS;
                S_IPOS: begin
                    if (cnt_reg[lst_reg] == CW'(bphe_pkg::HOLE_DEPTH)) begin
                        // list full: drop the hole
                        ovf_reg             <= 1'b1;
                        pend_v_reg[lst_reg] <= 1'b0;
                        state_reg           <= S_IN0;
                    end else begin
                        j_reg     <= cnt_reg[lst_reg];
                        state_reg <= S_IR;
                    end
                end
                S_IR: begin
                    if (j_reg == '0) begin
                        cnt_reg[lst_reg]    <= cnt_reg[lst_reg] + CW'(1);
                        pend_v_reg[lst_reg] <= 1'b0;
                        state_reg           <= S_IN0;
                    end else begin
                        state_reg <= S_IW;
                    end
                end
                S_IW: begin
                    if (rd_reg.vol > prod_reg) begin
                        // larger entry moves up one place
                        j_reg     <= j_reg - CW'(1);
                        state_reg <= S_IR;
                    end else begin
                        cnt_reg[lst_reg]    <= cnt_reg[lst_reg] + CW'(1);
                        pend_v_reg[lst_reg] <= 1'b0;
                        state_reg           <= S_IN0;
                    end
                end
                S_FIN: begin
                    if (kind_reg != bphe_pkg::KIND_NONE) begin
                        vt_reg  <= vt_reg + bv_reg;
                        wtt_reg <= wtt_reg + wt_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid         <= 1'b1;
                        m_placed        <= (kind_reg != bphe_pkg::KIND_NONE);
                        m_place_kind    <= kind_reg;
                        m_stopped       <= stop_reg;
                        m_hole_overflow <= ovf_reg;
                        m_packed_volume <= vt_reg;
                        m_packed_weight <= wtt_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg[0] <= CW'(bphe_pkg::HOLE_DEPTH)) && (cnt_reg[1] <= CW'(bphe_pkg::HOLE_DEPTH)) &&
        (cnt_reg[2] <= CW'(bphe_pkg::HOLE_DEPTH)))
        else $error("hole count beyond list depth");

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg && !(acc && s_start_new) |=> stop_reg)
        else $error("stop flag dropped without start_new");

    a_fw_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        !(acc && s_start_new) |=> (fw_reg <= $past(fw_reg)))
        else $error("free width grew without start_new");

    a_placed_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_placed == (m_place_kind != bphe_pkg::KIND_NONE)))
        else $error("placed flag disagrees with place kind");

    a_stop_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK) && stop_reg |=> (kind_reg == bphe_pkg::KIND_NONE))
        else $error("stopped evaluation placed a box");

endmodule

FILE: rtl/box_placement_hole_engine_top.sv
// ----------------------------------------------------------------------------
// box_placement_hole_engine_top
// Box placement engine with APB configuration registers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          content
//  s_*       in         s_valid/s_ready    box dimensions, weight, rotation
//  m_*       out        m_valid/m_ready    placement result and running totals
//  apb       in/out     psel/penable       container size, weight limit
//
//  Acceptance forms the box and container volumes; a stopped or over-limit box
//  then goes to the result. Otherwise the lists are searched entry by entry, a
//  new level is tried when no hole fits, a used hole is removed by moving later
//  entries down, and each new hole is inserted in volume order by moving
//  larger entries up, or dropped when its list is full. The next box is taken
//  only when the previous one is done; a result waits in the output register.
//  Reset is synchronous, active low; no clearing pass, hole lists start empty.
// ----------------------------------------------------------------------------
module box_placement_hole_engine_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bphe_pkg::PADDR_W-1:0]        paddr,
    input  logic [bphe_pkg::PDATA_W-1:0]        pwdata,
    output logic [bphe_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_start_new,
    input  logic [bphe_pkg::DIM_W-1:0]          s_box_length,
    input  logic [bphe_pkg::DIM_W-1:0]          s_box_width,
    input  logic [bphe_pkg::DIM_W-1:0]          s_box_height,
    input  logic [bphe_pkg::WT_W-1:0]           s_box_weight,
    input  logic [bphe_pkg::ROT_W-1:0]          s_rotation,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_placed,
    output logic [bphe_pkg::KIND_W-1:0]         m_place_kind,
    output logic                                m_stopped,
    output logic                                m_hole_overflow,
    output logic [bphe_pkg::VOL_W-1:0]          m_packed_volume,
    output logic [bphe_pkg::WT_W-1:0]           m_packed_weight
);

    bphe_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.length       <= bphe_pkg::RST_LENGTH;
            cfg_reg.width        <= bphe_pkg::RST_WIDTH;
            cfg_reg.height       <= bphe_pkg::RST_HEIGHT;
            cfg_reg.weight_limit <= bphe_pkg::RST_WLIMIT;
        end else if (wr_en) begin
            case (reg_idx)
                bphe_pkg::REG_LENGTH: cfg_reg.length       <= pwdata[bphe_pkg::DIM_W-1:0];
                bphe_pkg::REG_WIDTH:  cfg_reg.width        <= pwdata[bphe_pkg::DIM_W-1:0];
                bphe_pkg::REG_HEIGHT: cfg_reg.height       <= pwdata[bphe_pkg::DIM_W-1:0];
                bphe_pkg::REG_WLIMIT: cfg_reg.weight_limit <= pwdata[bphe_pkg::WT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bphe_pkg::REG_LENGTH: prdata = bphe_pkg::PDATA_W'(cfg_reg.length);
            bphe_pkg::REG_WIDTH:  prdata = bphe_pkg::PDATA_W'(cfg_reg.width);
            bphe_pkg::REG_HEIGHT: prdata = bphe_pkg::PDATA_W'(cfg_reg.height);
            bphe_pkg::REG_WLIMIT: prdata = bphe_pkg::PDATA_W'(cfg_reg.weight_limit);
            default:              prdata = '0;
        endcase
    end

    bphe_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_new     (s_start_new),
        .s_box_length    (s_box_length),
        .s_box_width     (s_box_width),
        .s_box_height    (s_box_height),
        .s_box_weight    (s_box_weight),
        .s_rotation      (s_rotation),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_placed        (m_placed),
        .m_place_kind    (m_place_kind),
        .m_stopped       (m_stopped),
        .m_hole_overflow (m_hole_overflow),
        .m_packed_volume (m_packed_volume),
        .m_packed_weight (m_packed_weight)
    );

endmodule
